// ----- hdl/probe_wind_to_ned_rotation_top_assert.svh -----
// Assertion macros for the probe wind rotation block.
// Relies on clk_i and rst_ni being visible where a macro is used.
`ifndef PROBE_WIND_TO_NED_ROTATION_TOP_ASSERT_SVH
`define PROBE_WIND_TO_NED_ROTATION_TOP_ASSERT_SVH

// ante implies cons in the same cycle, sampled on clk_i
`define PWNR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pwnr assertion failed");

// expr holds at every clock edge out of reset
`define PWNR_ASSERT_ALW(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("pwnr assertion failed");

`endif

// ----- hdl/pwnr_pkg.sv -----
// Shared types, constants and latencies of the probe wind rotation block.
// No dependencies.
package pwnr_pkg;

  localparam int ANGLE_BITS_DEF      = 16;
  localparam int SPEED_FRAC_BITS_DEF = 8;

  localparam int SC_W   = 32;
  localparam int Z_W    = 34;
  localparam int NUM_W  = 48;
  localparam int OUT_W  = 24;
  localparam int R_W    = 34;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int DIV_LAT      = OUT_W + 2;
  localparam int MAT_LAT      = 4;
  localparam int ROT_LAT      = 2;
  localparam int RES_STAGE    = CORDIC_LAT + 1 + DIV_LAT + ROT_LAT;
  localparam int PIPE_LAT     = RES_STAGE + 1;

  typedef logic signed [SC_W-1:0]  sc_t;
  typedef logic signed [R_W-1:0]   rent_t;
  typedef rent_t                   rmat_t [9];
  typedef logic signed [OUT_W-1:0] out_t;

  localparam sc_t  CORDIC_START = 32'sh26DD3B6A;
  localparam out_t OUT_MAX      = 24'sh7FFFFF;
  localparam out_t OUT_MIN      = 24'sh800000;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    REG_MOUNT_ROLL  = 2'd0,
    REG_MOUNT_PITCH = 2'd1,
    REG_MOUNT_YAW   = 2'd2
  } cfg_reg_e;

endpackage

// ----- hdl/pwnr_cordic.sv -----
// Pipelined CORDIC sine and cosine, one iteration per stage, Q30 results.
// Depends on pwnr_pkg.
module pwnr_cordic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [31:0]    phase_i,
  output logic           valid_o,
  output pwnr_pkg::sc_t  sin_o,
  output pwnr_pkg::sc_t  cos_o
);
  import pwnr_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic                  v_q   [N+1];
  sc_t                   x_q   [N+1];
  sc_t                   y_q   [N+1];
  logic signed [Z_W-1:0] z_q   [N+1];
  logic                  neg_q [N+1];
  logic [31:0]           fold;
  logic                  neg_in;

  always_comb begin
    neg_in = (phase_i > 32'h4000_0000) && (phase_i <= 32'hC000_0000);
    fold   = neg_in ? phase_i - 32'h8000_0000 : phase_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= N; k++) v_q[k] <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= N; k++) v_q[k] <= v_q[k-1];
      valid_o <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= CORDIC_START;
    y_q[0]   <= '0;
    z_q[0]   <= Z_W'(signed'(fold));
    neg_q[0] <= neg_in;
    for (int i = 0; i < N; i++) begin
      if (!z_q[i][Z_W-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - signed'(Z_W'(ATAN_TAB[i]));
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + signed'(Z_W'(ATAN_TAB[i]));
      end
      neg_q[i+1] <= neg_q[i];
    end
    sin_o <= neg_q[N] ? -y_q[N] : y_q[N];
    cos_o <= neg_q[N] ? -x_q[N] : x_q[N];
  end

endmodule

// ----- hdl/pwnr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, truncating
// towards zero and saturating to the output width. Depends on pwnr_pkg.
module pwnr_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [pwnr_pkg::NUM_W-1:0] num_i,
  input  pwnr_pkg::sc_t                  den_i,
  output logic                           valid_o,
  output pwnr_pkg::out_t                 quo_o
);
  import pwnr_pkg::*;

  localparam int Q     = OUT_W;
  localparam int NM_W  = NUM_W - 1;
  localparam int CMP_W = SC_W + OUT_W;

  logic              v_q    [Q+1];
  logic [NM_W-1:0]   rem_q  [Q+1];
  logic [Q-1:0]      quo_q  [Q+1];
  logic [SC_W-1:0]   d_q    [Q+1];
  logic              neg_q  [Q+1];
  logic              dz_q   [Q+1];
  logic              npos_q [Q+1];
  logic              nneg_q [Q+1];
  logic              ovf_q  [Q+1];

  logic [NUM_W-1:0]  nabs;
  logic [SC_W-1:0]   dabs;
  logic [CMP_W-1:0]  trial [Q];
  out_t              res;

  always_comb begin
    nabs = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    dabs = den_i[SC_W-1] ? SC_W'(-den_i) : SC_W'(den_i);
    for (int j = 0; j < Q; j++) begin
      trial[j] = CMP_W'(d_q[j]) << (Q - 1 - j);
    end
  end

  always_comb begin
    if (dz_q[Q]) begin
      res = npos_q[Q] ? OUT_MAX : (nneg_q[Q] ? OUT_MIN : '0);
    end else if (ovf_q[Q] || quo_q[Q][Q-1]) begin
      res = neg_q[Q] ? OUT_MIN : OUT_MAX;
    end else begin
      res = neg_q[Q] ? -out_t'(quo_q[Q]) : out_t'(quo_q[Q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Q; k++) v_q[k] <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= Q; k++) v_q[k] <= v_q[k-1];
      valid_o <= v_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= nabs[NM_W-1:0];
    quo_q[0]  <= '0;
    d_q[0]    <= dabs;
    neg_q[0]  <= num_i[NUM_W-1] ^ den_i[SC_W-1];
    dz_q[0]   <= (den_i == '0);
    npos_q[0] <= !num_i[NUM_W-1] && (num_i != '0);
    nneg_q[0] <= num_i[NUM_W-1];
    ovf_q[0]  <= CMP_W'(nabs) >= (CMP_W'(dabs) << Q);
    for (int j = 0; j < Q; j++) begin
      if (CMP_W'(rem_q[j]) >= trial[j]) begin
        rem_q[j+1] <= rem_q[j] - NM_W'(trial[j]);
        quo_q[j+1] <= quo_q[j] | (Q'(1) << (Q - 1 - j));
      end else begin
        rem_q[j+1] <= rem_q[j];
        quo_q[j+1] <= quo_q[j];
      end
      d_q[j+1]    <= d_q[j];
      neg_q[j+1]  <= neg_q[j];
      dz_q[j+1]   <= dz_q[j];
      npos_q[j+1] <= npos_q[j];
      nneg_q[j+1] <= nneg_q[j];
      ovf_q[j+1]  <= ovf_q[j];
    end
    quo_o <= res;
  end

endmodule

// ----- hdl/pwnr_matrix.sv -----
// Builds the ZYX rotation matrix from attitude sines and cosines over
// four stages. Depends on pwnr_pkg.
module pwnr_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  pwnr_pkg::sc_t  sin_r_i,
  input  pwnr_pkg::sc_t  cos_r_i,
  input  pwnr_pkg::sc_t  sin_p_i,
  input  pwnr_pkg::sc_t  cos_p_i,
  input  pwnr_pkg::sc_t  sin_y_i,
  input  pwnr_pkg::sc_t  cos_y_i,
  output logic           valid_o,
  output pwnr_pkg::rmat_t rmat_o
);
  import pwnr_pkg::*;

  function automatic rent_t rnd30(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = (p + 66'sd536870912) >>> 30;
    return rent_t'(s[R_W-1:0]);
  endfunction

  logic [MAT_LAT-1:0] v_q;

  // first products
  logic signed [63:0] p_cycp_q, p_cysp_q, p_sycr_q, p_sysr_q, p_sycp_q;
  logic signed [63:0] p_sysp_q, p_cycr_q, p_cysr_q, p_cpsr_q, p_cpcr_q;
  sc_t                sr1_q, cr1_q, sp1_q;
  // rounded
  rent_t m_cycp_q, m_cysp_q, m_sycr_q, m_sysr_q, m_sycp_q;
  rent_t m_sysp_q, m_cycr_q, m_cysr_q, m_cpsr_q, m_cpcr_q;
  sc_t   sr2_q, cr2_q, sp2_q;
  // second products
  logic signed [65:0] q_cyspsr_q, q_cyspcr_q, q_syspsr_q, q_syspcr_q;
  rent_t m3_cycp_q, m3_sycr_q, m3_sysr_q, m3_sycp_q;
  rent_t m3_cycr_q, m3_cysr_q, m3_cpsr_q, m3_cpcr_q;
  sc_t   sp3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[MAT_LAT-2:0], valid_i};
    end
  end

  assign valid_o = v_q[MAT_LAT-1];

  always_ff @(posedge clk_i) begin
    p_cycp_q <= cos_y_i * cos_p_i;
    p_cysp_q <= cos_y_i * sin_p_i;
    p_sycr_q <= sin_y_i * cos_r_i;
    p_sysr_q <= sin_y_i * sin_r_i;
    p_sycp_q <= sin_y_i * cos_p_i;
    p_sysp_q <= sin_y_i * sin_p_i;
    p_cycr_q <= cos_y_i * cos_r_i;
    p_cysr_q <= cos_y_i * sin_r_i;
    p_cpsr_q <= cos_p_i * sin_r_i;
    p_cpcr_q <= cos_p_i * cos_r_i;
    sr1_q    <= sin_r_i;
    cr1_q    <= cos_r_i;
    sp1_q    <= sin_p_i;

    m_cycp_q <= rnd30(66'(p_cycp_q));
    m_cysp_q <= rnd30(66'(p_cysp_q));
    m_sycr_q <= rnd30(66'(p_sycr_q));
    m_sysr_q <= rnd30(66'(p_sysr_q));
    m_sycp_q <= rnd30(66'(p_sycp_q));
    m_sysp_q <= rnd30(66'(p_sysp_q));
    m_cycr_q <= rnd30(66'(p_cycr_q));
    m_cysr_q <= rnd30(66'(p_cysr_q));
    m_cpsr_q <= rnd30(66'(p_cpsr_q));
    m_cpcr_q <= rnd30(66'(p_cpcr_q));
    sr2_q    <= sr1_q;
    cr2_q    <= cr1_q;
    sp2_q    <= sp1_q;

    q_cyspsr_q <= m_cysp_q * sr2_q;
    q_cyspcr_q <= m_cysp_q * cr2_q;
    q_syspsr_q <= m_sysp_q * sr2_q;
    q_syspcr_q <= m_sysp_q * cr2_q;
    m3_cycp_q  <= m_cycp_q;
    m3_sycr_q  <= m_sycr_q;
    m3_sysr_q  <= m_sysr_q;
    m3_sycp_q  <= m_sycp_q;
    m3_cycr_q  <= m_cycr_q;
    m3_cysr_q  <= m_cysr_q;
    m3_cpsr_q  <= m_cpsr_q;
    m3_cpcr_q  <= m_cpcr_q;
    sp3_q      <= sp2_q;

    rmat_o[0] <= m3_cycp_q;
    rmat_o[1] <= rnd30(q_cyspsr_q) - m3_sycr_q;
    rmat_o[2] <= rnd30(q_cyspcr_q) + m3_sysr_q;
    rmat_o[3] <= m3_sycp_q;
    rmat_o[4] <= rnd30(q_syspsr_q) + m3_cycr_q;
    rmat_o[5] <= rnd30(q_syspcr_q) - m3_cysr_q;
    rmat_o[6] <= -R_W'(sp3_q);
    rmat_o[7] <= m3_cpsr_q;
    rmat_o[8] <= m3_cpcr_q;
  end

endmodule

// ----- hdl/pwnr_rotate.sv -----
// Rotates one probe-frame vector by the matrix: products, then rounded and
// saturated sums. Depends on pwnr_pkg.
module pwnr_rotate (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  pwnr_pkg::rmat_t rmat_i,
  input  pwnr_pkg::out_t  x_i,
  input  pwnr_pkg::out_t  y_i,
  input  pwnr_pkg::out_t  z_i,
  output logic            valid_o,
  output pwnr_pkg::out_t  n_o,
  output pwnr_pkg::out_t  e_o,
  output pwnr_pkg::out_t  d_o
);
  import pwnr_pkg::*;

  localparam int P_W = R_W + OUT_W;
  localparam int A_W = P_W + 2;

  logic                  v_q;
  out_t                  vec    [3];
  logic signed [P_W-1:0] prod_q [9];
  logic signed [A_W-1:0] acc    [3];
  out_t                  res    [3];

  always_comb begin
    vec[0] = x_i;
    vec[1] = y_i;
    vec[2] = z_i;
    for (int k = 0; k < 3; k++) begin
      acc[k] = (A_W'(prod_q[3*k]) + A_W'(prod_q[3*k+1]) + A_W'(prod_q[3*k+2])
                + A_W'(64'sd536870912)) >>> 30;
      if (acc[k] > A_W'(OUT_MAX)) begin
        res[k] = OUT_MAX;
      end else if (acc[k] < A_W'(OUT_MIN)) begin
        res[k] = OUT_MIN;
      end else begin
        res[k] = acc[k][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= valid_i;
      valid_o <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      prod_q[k] <= rmat_i[k] * vec[k % 3];
    end
    n_o <= res[0];
    e_o <= res[1];
    d_o <= res[2];
  end

endmodule

// ----- hdl/probe_wind_to_ned_rotation_top.sv -----
// Probe wind to north-east-down rotation: a request each cycle.
// Register stages from request to done_o: accept register, CORDIC 26, speed product 1,
// quotient 26, rotation 2. Throughput: one request per cycle.
// busy_o stays low; the receiver cannot stall. Reset clears valid bits and mount offsets.
// Depends on pwnr_pkg, pwnr_cordic, pwnr_div, pwnr_matrix, pwnr_rotate.
module probe_wind_to_ned_rotation_top #(
  parameter int ANGLE_BITS      = pwnr_pkg::ANGLE_BITS_DEF,
  parameter int SPEED_FRAC_BITS = pwnr_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic signed [15:0]  roll_angle_i,
  input  logic signed [15:0]  pitch_angle_i,
  input  logic signed [15:0]  yaw_angle_i,
  input  logic signed [15:0]  wind_speed_i,
  input  logic signed [15:0]  flow_angle_ew_i,
  input  logic signed [15:0]  flow_angle_ns_i,
  input  logic signed [15:0]  filtered_speed_i,
  input  logic signed [15:0]  filtered_angle_ew_i,
  input  logic signed [15:0]  filtered_angle_ns_i,
  output logic                done_o,
  output pwnr_pkg::out_t      north_wind_o,
  output pwnr_pkg::out_t      east_wind_o,
  output pwnr_pkg::out_t      down_wind_o,
  output pwnr_pkg::out_t      north_wind_filtered_o,
  output pwnr_pkg::out_t      east_wind_filtered_o,
  output pwnr_pkg::out_t      down_wind_filtered_o,
  output logic                speed_valid_o
);
  import pwnr_pkg::*;

  localparam int PH_SH = 32 - ANGLE_BITS;
  localparam int D_ATT = 1 + DIV_LAT - MAT_LAT;
  localparam int SP_N  = CORDIC_LAT + DIV_LAT + 2;
  localparam int X_TAP = CORDIC_LAT + 1 + DIV_LAT;

  function automatic logic [31:0] to_phase(input logic [15:0] f);
    return {{16{f[15]}}, f} << PH_SH;
  endfunction

  logic [15:0]  mount_roll_q, mount_pitch_q, mount_yaw_q;

  logic         att_v_q  [D_ATT+1];
  logic [31:0]  ph_r_q   [D_ATT+1];
  logic [31:0]  ph_p_q   [D_ATT+1];
  logic [31:0]  ph_y_q   [D_ATT+1];
  logic [31:0]  ph_ew_q, ph_ns_q, ph_few_q, ph_fns_q;
  logic signed [15:0] ws_q [SP_N];
  logic signed [15:0] fs_q [SP_N];
  logic         sv_q     [RES_STAGE+1];

  logic [16:0]  spd_abs;
  logic [23:0]  spd_x100;

  logic [3:0]   fl_v;
  sc_t          fl_sin [4];
  sc_t          fl_cos [4];
  logic         num_v_q;
  logic signed [NUM_W-1:0] num_q [4];
  sc_t          den_q  [4];
  logic [3:0]   dv_v;
  out_t         lat    [4];

  logic [2:0]   at_v;
  sc_t          at_sin [3];
  sc_t          at_cos [3];
  logic         mat_v;
  rmat_t        rmat;

  logic         rot_vi;
  logic [1:0]   rot_vo;
  logic [31:0]  att_in [3];
  logic [31:0]  fl_in  [4];
  logic signed [15:0] fl_spd [4];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mount_roll_q  <= '0;
      mount_pitch_q <= '0;
      mount_yaw_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_MOUNT_ROLL:  mount_roll_q  <= cfg_wdata_i;
        REG_MOUNT_PITCH: mount_pitch_q <= cfg_wdata_i;
        REG_MOUNT_YAW:   mount_yaw_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    spd_abs  = wind_speed_i[15] ? 17'(-17'(wind_speed_i)) : 17'(wind_speed_i);
    spd_x100 = 24'(spd_abs) * 24'd100;
  end

  // accept, and align attitude and speeds with the flow-angle path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= D_ATT; k++) att_v_q[k] <= 1'b0;
    end else begin
      att_v_q[0] <= start_i && !busy_o;
      for (int k = 1; k <= D_ATT; k++) att_v_q[k] <= att_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ph_r_q[0] <= to_phase(roll_angle_i) + to_phase(mount_roll_q);
    ph_p_q[0] <= to_phase(pitch_angle_i) + to_phase(mount_pitch_q);
    ph_y_q[0] <= to_phase(yaw_angle_i) + to_phase(mount_yaw_q);
    for (int k = 1; k <= D_ATT; k++) begin
      ph_r_q[k] <= ph_r_q[k-1];
      ph_p_q[k] <= ph_p_q[k-1];
      ph_y_q[k] <= ph_y_q[k-1];
    end
    ph_ew_q  <= to_phase(flow_angle_ew_i);
    ph_ns_q  <= to_phase(flow_angle_ns_i);
    ph_few_q <= to_phase(filtered_angle_ew_i);
    ph_fns_q <= to_phase(filtered_angle_ns_i);
    ws_q[0]  <= wind_speed_i;
    fs_q[0]  <= filtered_speed_i;
    for (int k = 1; k < SP_N; k++) begin
      ws_q[k] <= ws_q[k-1];
      fs_q[k] <= fs_q[k-1];
    end
    sv_q[0] <= spd_x100 > (24'(1) << SPEED_FRAC_BITS);
    for (int k = 1; k <= RES_STAGE; k++) sv_q[k] <= sv_q[k-1];
  end

  assign fl_in[0]  = ph_ew_q;
  assign fl_in[1]  = ph_ns_q;
  assign fl_in[2]  = ph_few_q;
  assign fl_in[3]  = ph_fns_q;
  assign fl_spd[0] = ws_q[CORDIC_LAT];
  assign fl_spd[1] = ws_q[CORDIC_LAT];
  assign fl_spd[2] = fs_q[CORDIC_LAT];
  assign fl_spd[3] = fs_q[CORDIC_LAT];

  for (genvar g = 0; g < 4; g++) begin : g_flow
    pwnr_cordic u_cordic (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (att_v_q[0]),
      .phase_i (fl_in[g]),
      .valid_o (fl_v[g]),
      .sin_o   (fl_sin[g]),
      .cos_o   (fl_cos[g])
    );

    always_ff @(posedge clk_i) begin
      num_q[g] <= NUM_W'(fl_spd[g]) * NUM_W'(fl_sin[g]);
      den_q[g] <= fl_cos[g];
    end

    pwnr_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (num_v_q),
      .num_i   (num_q[g]),
      .den_i   (den_q[g]),
      .valid_o (dv_v[g]),
      .quo_o   (lat[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_v_q <= 1'b0;
    end else begin
      num_v_q <= &fl_v;
    end
  end

  assign att_in[0] = ph_r_q[D_ATT];
  assign att_in[1] = ph_p_q[D_ATT];
  assign att_in[2] = ph_y_q[D_ATT];

  for (genvar g = 0; g < 3; g++) begin : g_att
    pwnr_cordic u_cordic (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (att_v_q[D_ATT]),
      .phase_i (att_in[g]),
      .valid_o (at_v[g]),
      .sin_o   (at_sin[g]),
      .cos_o   (at_cos[g])
    );
  end

  pwnr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (&at_v),
    .sin_r_i (at_sin[0]),
    .cos_r_i (at_cos[0]),
    .sin_p_i (at_sin[1]),
    .cos_p_i (at_cos[1]),
    .sin_y_i (at_sin[2]),
    .cos_y_i (at_cos[2]),
    .valid_o (mat_v),
    .rmat_o  (rmat)
  );

  assign rot_vi = mat_v && (&dv_v);

  pwnr_rotate u_rot_raw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_vi),
    .rmat_i  (rmat),
    .x_i     (OUT_W'(ws_q[X_TAP])),
    .y_i     (lat[0]),
    .z_i     (lat[1]),
    .valid_o (rot_vo[0]),
    .n_o     (north_wind_o),
    .e_o     (east_wind_o),
    .d_o     (down_wind_o)
  );

  pwnr_rotate u_rot_filt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_vi),
    .rmat_i  (rmat),
    .x_i     (OUT_W'(fs_q[X_TAP])),
    .y_i     (lat[2]),
    .z_i     (lat[3]),
    .valid_o (rot_vo[1]),
    .n_o     (north_wind_filtered_o),
    .e_o     (east_wind_filtered_o),
    .d_o     (down_wind_filtered_o)
  );

  assign done_o        = &rot_vo;
  assign speed_valid_o = sv_q[RES_STAGE];

endmodule

// ----- hdl/pwnr_chk.sv -----
// Port-level checks on the probe wind rotation block, bound to its top level.
// Depends on pwnr_pkg and probe_wind_to_ned_rotation_top_assert.svh.
`include "probe_wind_to_ned_rotation_top_assert.svh"

module pwnr_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic signed [15:0] wind_speed_i,
  input logic               speed_valid_o
);
  import pwnr_pkg::*;

  `PWNR_ASSERT_ALW(a_never_busy, !busy_o)
  `PWNR_ASSERT_IMP(a_done_has_request, done_o, $past(start_i && !busy_o, PIPE_LAT))
  `PWNR_ASSERT_IMP(a_request_gives_done, start_i && !busy_o, ##PIPE_LAT done_o)
  `PWNR_ASSERT_IMP(a_valid_needs_speed, done_o && speed_valid_o,
                   $past(wind_speed_i, PIPE_LAT) != 16'sd0)

endmodule

bind probe_wind_to_ned_rotation_top pwnr_chk u_pwnr_chk (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for probe_wind_to_ned_rotation_top: directed table, then random requests.
// Predicts each untyped result, expects zeros for typed rows, compares field by field. Depends on pwnr_pkg.
module tb_top;
  import pwnr_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic signed [15:0] roll, pitch, yaw;
    logic signed [15:0] ws, w_ew, w_ns;
    logic signed [15:0] fs, f_ew, f_ns;
  } probe_req_t;

  typedef struct {
    out_t n, e, d, nf, ef, df;
    logic valid;
  } ned_wind_t;

  typedef struct {
    bit        typed;
    ned_wind_t wind;
  } req_note_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic signed [15:0] roll_angle_i = '0, pitch_angle_i = '0, yaw_angle_i = '0;
  logic signed [15:0] wind_speed_i = '0, flow_angle_ew_i = '0, flow_angle_ns_i = '0;
  logic signed [15:0] filtered_speed_i = '0, filtered_angle_ew_i = '0;
  logic signed [15:0] filtered_angle_ns_i = '0;
  logic done_o, speed_valid_o;
  out_t north_wind_o, east_wind_o, down_wind_o;
  out_t north_wind_filtered_o, east_wind_filtered_o, down_wind_filtered_o;

  logic [15:0] mount [3];
  req_note_t   note_q [$];
  ned_wind_t   wind_q [$];
  probe_req_t  drive_q [$];
  bit          typed_row [$];
  int          n_err = 0;
  int          n_checked = 0;
  bit          idle_on = 1'b1;

  probe_wind_to_ned_rotation_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .roll_angle_i, .pitch_angle_i, .yaw_angle_i, .wind_speed_i, .flow_angle_ew_i,
    .flow_angle_ns_i, .filtered_speed_i, .filtered_angle_ew_i, .filtered_angle_ns_i,
    .done_o, .north_wind_o, .east_wind_o, .down_wind_o, .north_wind_filtered_o,
    .east_wind_filtered_o, .down_wind_filtered_o, .speed_valid_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic logic [31:0] phase_of(logic [15:0] a);
    return {a, 16'h0000};
  endfunction

  function automatic void cordic_sin_cos(input logic [31:0] ph, output longint sn,
                                         output longint cs);
    logic [31:0] p;
    bit     flip;
    longint x, y, z, nx;
    p = ph;
    flip = 1'b0;
    x = longint'(CORDIC_START);
    y = 0;
    if (p > 32'h40000000 && p <= 32'hC0000000) begin
      p = p - 32'h80000000;
      flip = 1'b1;
    end
    z = longint'($signed(p));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint cross_term(longint spd, logic [15:0] ang);
    longint sn, cs, num;
    cordic_sin_cos(phase_of(ang), sn, cs);
    num = spd * sn;
    if (cs == 0) begin
      if (num > 0) return 64'sd8388607;
      if (num < 0) return -64'sd8388608;
      return 0;
    end
    return clamp24(num / cs);
  endfunction

  function automatic out_t ned_row(longint r0, longint r1, longint r2,
                                   longint x, longint y, longint z);
    return out_t'(clamp24((r0 * x + r1 * y + r2 * z + 64'sd536870912) >>> 30));
  endfunction

  function automatic ned_wind_t predict_wind(probe_req_t q);
    ned_wind_t w;
    longint sr, cr, sp, cp, sy, cy, spd;
    longint r [9];
    longint wy, wz, fy, fz;
    cordic_sin_cos(phase_of(q.roll) + phase_of(mount[REG_MOUNT_ROLL]), sr, cr);
    cordic_sin_cos(phase_of(q.pitch) + phase_of(mount[REG_MOUNT_PITCH]), sp, cp);
    cordic_sin_cos(phase_of(q.yaw) + phase_of(mount[REG_MOUNT_YAW]), sy, cy);
    r[0] = qmul(cy, cp);
    r[1] = qmul(qmul(cy, sp), sr) - qmul(sy, cr);
    r[2] = qmul(qmul(cy, sp), cr) + qmul(sy, sr);
    r[3] = qmul(sy, cp);
    r[4] = qmul(qmul(sy, sp), sr) + qmul(cy, cr);
    r[5] = qmul(qmul(sy, sp), cr) - qmul(cy, sr);
    r[6] = -sp;
    r[7] = qmul(cp, sr);
    r[8] = qmul(cp, cr);
    wy = cross_term(q.ws, q.w_ew);
    wz = cross_term(q.ws, q.w_ns);
    fy = cross_term(q.fs, q.f_ew);
    fz = cross_term(q.fs, q.f_ns);
    w.n  = ned_row(r[0], r[1], r[2], q.ws, wy, wz);
    w.e  = ned_row(r[3], r[4], r[5], q.ws, wy, wz);
    w.d  = ned_row(r[6], r[7], r[8], q.ws, wy, wz);
    w.nf = ned_row(r[0], r[1], r[2], q.fs, fy, fz);
    w.ef = ned_row(r[3], r[4], r[5], q.fs, fy, fz);
    w.df = ned_row(r[6], r[7], r[8], q.fs, fy, fz);
    spd = q.ws < 0 ? -longint'(q.ws) : longint'(q.ws);
    w.valid = (spd * 100 > (64'sd1 << SPEED_FRAC_BITS_DEF));
    return w;
  endfunction

  task automatic check_field(string name, out_t e, out_t a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin
    req_note_t  nt;
    ned_wind_t  w;
    probe_req_t q;
    if (rst_ni && start_i && !busy_o) begin
      q = '{roll_angle_i, pitch_angle_i, yaw_angle_i, wind_speed_i, flow_angle_ew_i,
            flow_angle_ns_i, filtered_speed_i, filtered_angle_ew_i, filtered_angle_ns_i};
      nt = note_q.pop_front();
      wind_q.push_back(nt.typed ? nt.wind : predict_wind(q));
    end
    if (rst_ni && done_o) begin
      if (wind_q.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        n_err++;
      end else begin
        w = wind_q.pop_front();
        n_checked++;
        check_field("north_wind", w.n, north_wind_o);
        check_field("east_wind", w.e, east_wind_o);
        check_field("down_wind", w.d, down_wind_o);
        check_field("north_wind_filtered", w.nf, north_wind_filtered_o);
        check_field("east_wind_filtered", w.ef, east_wind_filtered_o);
        check_field("down_wind_filtered", w.df, down_wind_filtered_o);
        if (w.valid !== speed_valid_o) begin
          $display("%0t: speed_valid mismatch, expected %0b, got %0b", $time, w.valid,
                   speed_valid_o);
          n_err++;
        end
      end
    end
  end

  task automatic send_request(probe_req_t q, bit typed);
    req_note_t nt;
    if (idle_on && $urandom_range(99) < 15) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    nt.typed = typed;
    nt.wind = '{default: '0};
    note_q.push_back(nt);
    start_i <= 1'b1;
    roll_angle_i <= q.roll;
    pitch_angle_i <= q.pitch;
    yaw_angle_i <= q.yaw;
    wind_speed_i <= q.ws;
    flow_angle_ew_i <= q.w_ew;
    flow_angle_ns_i <= q.w_ns;
    filtered_speed_i <= q.fs;
    filtered_angle_ew_i <= q.f_ew;
    filtered_angle_ns_i <= q.f_ns;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (wind_q.size() != 0 || note_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr != REG_SPARE) mount[addr] = val;
  endtask

  function automatic logic signed [15:0] rand_speed();
    case ($urandom_range(3))
      0: return 16'($urandom_range(600));
      1: return -$signed(16'($urandom_range(600)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic probe_req_t rand_request();
    probe_req_t q;
    q = '{16'($urandom), 16'($urandom), 16'($urandom), rand_speed(), 16'($urandom),
          16'($urandom), rand_speed(), 16'($urandom), 16'($urandom)};
    if ($urandom_range(3) == 0) begin
      q.w_ew = $signed(16'($urandom_range(2000))) - 16'sd1000;
      q.f_ns = $signed(16'($urandom_range(2000))) - 16'sd1000;
    end
    return q;
  endfunction

  task automatic add_row(int r, int p, int y, int ws, int wew, int wns,
                         int fs, int few, int fns, bit typed);
    drive_q.push_back('{16'(r), 16'(p), 16'(y), 16'(ws), 16'(wew), 16'(wns),
                       16'(fs), 16'(few), 16'(fns)});
    typed_row.push_back(typed);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      idle_on = !(i >= count / 3 && i < count / 2);
      if (i == count * 3 / 4) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        while (wind_q.size() != 0) @(posedge clk_i);
      end
      send_request(rand_request(), 1'b0);
    end
    idle_on = 1'b1;
    drain();
  endtask

  initial begin
    mount = '{default: '0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    add_row(32767, -32768, 16384, 0, 16384, -16384, 0, 32767, -32768, 1);
    add_row(0, 0, 0, 256, 0, 0, 256, 0, 0, 0);
    add_row(0, 0, 0, 2, 0, 0, -2, 0, 0, 0);
    add_row(0, 0, 0, 3, 0, 0, 3, 0, 0, 0);
    add_row(0, 0, 0, -2, 0, 0, -3, 0, 0, 0);
    add_row(0, 0, 0, -3, 100, -100, 1, 0, 0, 0);
    add_row(0, 0, 0, 32767, 0, 0, -32768, 0, 0, 0);
    add_row(0, 0, 0, 32767, 16384, -16384, -32768, 16384, -16384, 0);
    add_row(0, 0, 0, -32768, 16383, 16385, 32767, -16383, -16385, 0);
    add_row(16384, 0, 0, 1000, 4096, 0, 1000, 0, 4096, 0);
    add_row(0, 16384, 0, 1000, 0, 0, 1000, 0, 0, 0);
    add_row(0, 0, 16384, 1000, 0, 0, 1000, 0, 0, 0);
    add_row(-32768, -32768, -32768, 1000, -32768, -32768, 1000, -32768, -32768, 0);
    add_row(32767, 32767, 32767, -1000, 32767, 32767, -1000, 32767, 32767, 0);
    add_row(8192, -8192, 24576, 32767, 8000, -8000, 32767, -8000, 8000, 0);
    add_row(-16384, 16383, -16385, -32768, 16000, 16000, -32768, -16000, -16000, 0);
    add_row(21845, 10923, -21845, 12345, -5000, 3000, -12345, 5000, -3000, 0);
    for (int i = 0; i < drive_q.size(); i++) begin
      send_request(drive_q[i], typed_row[i]);
    end
    drain();

    random_phase(300);
    write_reg(REG_MOUNT_ROLL, 16'h7FFF);
    write_reg(REG_MOUNT_PITCH, 16'h8000);
    write_reg(REG_MOUNT_YAW, 16'h7FFF);
    random_phase(250);
    write_reg(REG_MOUNT_ROLL, 16'h8000);
    write_reg(REG_MOUNT_PITCH, 16'h7FFF);
    write_reg(REG_MOUNT_YAW, 16'h8000);
    write_reg(REG_SPARE, 16'h1234);
    random_phase(250);
    write_reg(REG_MOUNT_ROLL, 16'($urandom));
    write_reg(REG_MOUNT_PITCH, 16'($urandom));
    write_reg(REG_MOUNT_YAW, 16'($urandom));
    random_phase(300);

    $display("Checked %0d results: directed table, then random requests under", n_checked);
    $display("zero, extreme and random mount offsets with gaps and a full drain.");
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/pwnr_pkg.sv
hdl/pwnr_cordic.sv
hdl/pwnr_div.sv
hdl/pwnr_matrix.sv
hdl/pwnr_rotate.sv
hdl/probe_wind_to_ned_rotation_top.sv
hdl/pwnr_chk.sv
verif/tb_top.sv
